// ===== sv/owtr_pkg.sv =====
// Package: shared types and constants for the 1-Wire temperature read master
`timescale 1ns / 1ps
`default_nettype none
package owtr_pkg;

  localparam int unsigned OWTR_READ_BYTES = 2;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 10;
  localparam int unsigned TICK_W          = 10;
  localparam int unsigned SLOT_W          = 8;
  localparam int unsigned TEMP_W          = 16;

  localparam logic [TICK_W-1:0] RST_LOW_DEF   = 10'd500;
  localparam logic [TICK_W-1:0] PRES_WAIT_DEF = 10'd60;
  localparam logic [TICK_W-1:0] RECOV_DEF     = 10'd240;
  localparam logic [SLOT_W-1:0] WR_SHORT_DEF  = 8'd2;
  localparam logic [SLOT_W-1:0] WR_LONG_DEF   = 8'd60;
  localparam logic [SLOT_W-1:0] RD_LOW_DEF    = 8'd1;
  localparam logic [SLOT_W-1:0] RD_REL_DEF    = 8'd1;
  localparam logic [SLOT_W-1:0] RD_TAIL_DEF   = 8'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RST_LOW   = 3'd0,
    CFG_PRES_WAIT = 3'd1,
    CFG_RECOV     = 3'd2,
    CFG_WR_SHORT  = 3'd3,
    CFG_WR_LONG   = 3'd4,
    CFG_RD_LOW    = 3'd5,
    CFG_RD_REL    = 3'd6,
    CFG_RD_TAIL   = 3'd7
  } cfg_idx_e;

  typedef enum logic [8:0] {
    PH_IDLE      = 9'b000000001,
    PH_RST_LOW   = 9'b000000010,
    PH_RST_WAIT  = 9'b000000100,
    PH_RST_RECOV = 9'b000001000,
    PH_WR_LOW    = 9'b000010000,
    PH_WR_HIGH   = 9'b000100000,
    PH_RD_LOW    = 9'b001000000,
    PH_RD_REL    = 9'b010000000,
    PH_RD_TAIL   = 9'b100000000
  } phase_e;

  typedef struct packed {
    logic [TICK_W-1:0] reset_low_ticks;
    logic [TICK_W-1:0] presence_wait_ticks;
    logic [TICK_W-1:0] recovery_ticks;
    logic [SLOT_W-1:0] write_short_ticks;
    logic [SLOT_W-1:0] write_long_ticks;
    logic [SLOT_W-1:0] read_low_ticks;
    logic [SLOT_W-1:0] read_release_ticks;
    logic [SLOT_W-1:0] read_tail_ticks;
  } cfg_t;

  typedef struct packed {
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic              no_presence;
    logic [TEMP_W-1:0] temperature_raw;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/owtr_in_if.sv =====
// Interface: request channel carrying one tick item
`timescale 1ns / 1ps
`default_nettype none
interface owtr_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic line_level;

  modport source (output valid, output start_req, output line_level, input ready);
  modport sink (input valid, input start_req, input line_level, output ready);
endinterface
`default_nettype wire

// ===== sv/owtr_out_if.sv =====
// Interface: result channel carrying line drive, status and temperature word
`timescale 1ns / 1ps
`default_nettype none
interface owtr_out_if;
  logic        valid;
  logic        ready;
  logic        drive_low;
  logic        busy_res;
  logic        done_res;
  logic        no_presence;
  logic [15:0] temperature_raw;

  modport source (
    output valid, output drive_low, output busy_res, output done_res,
    output no_presence, output temperature_raw, input ready
  );
  modport sink (
    input valid, input drive_low, input busy_res, input done_res,
    input no_presence, input temperature_raw, output ready
  );
endinterface
`default_nettype wire

// ===== sv/one_wire_temperature_read_master_top.sv =====
// Top level: 1-Wire temperature read master with timing registers and result register
//
// Usage:
//   req_i carries one tick request per bus microsecond: start_req and the
//   sampled line_level. res_o returns exactly one result per request: the
//   line drive, busy, a done pulse, a no-presence pulse and the last good
//   temperature word (first byte in 7:0, second in 15:8).
//   The result of a request accepted at one edge is registered and valid
//   after that edge. Throughput is one request per clock while res_o.ready
//   stays high; the per-tick phase step and slot counter sit between the
//   sequencer state and the result register.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the eight timing registers, to be
//   used while no transaction is running.
//   Reset puts the sequencer in idle, clears the temperature word and loads
//   the default timings.
//   When the receiver holds res_o.ready low with a result pending, req_i.ready
//   drops and the sequencer state holds until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module one_wire_temperature_read_master_top import owtr_pkg::*; #(
  parameter int unsigned READ_BYTES = OWTR_READ_BYTES
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  owtr_in_if.sink                    req_i,
  owtr_out_if.source                 res_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q;
  res_t res_d;
  res_t res_q;
  logic out_vld_q;
  logic accept;

  assign req_i.ready = !out_vld_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_ticks     <= RST_LOW_DEF;
      cfg_q.presence_wait_ticks <= PRES_WAIT_DEF;
      cfg_q.recovery_ticks      <= RECOV_DEF;
      cfg_q.write_short_ticks   <= WR_SHORT_DEF;
      cfg_q.write_long_ticks    <= WR_LONG_DEF;
      cfg_q.read_low_ticks      <= RD_LOW_DEF;
      cfg_q.read_release_ticks  <= RD_REL_DEF;
      cfg_q.read_tail_ticks     <= RD_TAIL_DEF;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RST_LOW:   cfg_q.reset_low_ticks     <= cfg_data_i;
        CFG_PRES_WAIT: cfg_q.presence_wait_ticks <= cfg_data_i;
        CFG_RECOV:     cfg_q.recovery_ticks      <= cfg_data_i;
        CFG_WR_SHORT:  cfg_q.write_short_ticks   <= cfg_data_i[SLOT_W-1:0];
        CFG_WR_LONG:   cfg_q.write_long_ticks    <= cfg_data_i[SLOT_W-1:0];
        CFG_RD_LOW:    cfg_q.read_low_ticks      <= cfg_data_i[SLOT_W-1:0];
        CFG_RD_REL:    cfg_q.read_release_ticks  <= cfg_data_i[SLOT_W-1:0];
        CFG_RD_TAIL:   cfg_q.read_tail_ticks     <= cfg_data_i[SLOT_W-1:0];
        default:       cfg_q <= cfg_q;
      endcase
    end
  end

  owtr_core #(
    .READ_BYTES (READ_BYTES)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (accept),
    .start_i (req_i.start_req),
    .level_i (req_i.line_level),
    .cfg_i   (cfg_q),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (accept) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid           = out_vld_q;
  assign res_o.drive_low       = res_q.drive_low;
  assign res_o.busy_res        = res_q.busy_res;
  assign res_o.done_res        = res_q.done_res;
  assign res_o.no_presence     = res_q.no_presence;
  assign res_o.temperature_raw = res_q.temperature_raw;

`ifndef SYNTH
  a_end_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(res_q.done_res && res_q.no_presence))
    else $error("done and no_presence in the same result");

  a_end_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (res_q.done_res || res_q.no_presence)) |-> !res_q.busy_res)
    else $error("transaction end reported while busy");

  a_stall_blocks_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_o.ready) |-> !req_i.ready)
    else $error("request taken while result stalled");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_o.ready) |=> (out_vld_q && $stable(res_q)))
    else $error("pending result lost or changed under stall");
`endif

endmodule
`default_nettype wire

// ===== sv/owtr_core.sv =====
// Bus sequencer: phase state, slot timing, command bits and read-bit capture
`timescale 1ns / 1ps
`default_nettype none
module owtr_core import owtr_pkg::*; #(
  parameter int unsigned READ_BYTES = OWTR_READ_BYTES
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic adv_i,
  input  wire logic start_i,
  input  wire logic level_i,
  input  wire cfg_t cfg_i,
  output res_t      res_o
);

  localparam int unsigned BYTE_W =
    ($clog2(READ_BYTES + 1) > 3) ? $clog2(READ_BYTES + 1) : 3;

  phase_e              phase_q, phase_d;
  logic [TICK_W-1:0]   tick_q, tick_d;
  logic [2:0]          bit_q, bit_d;
  logic [BYTE_W-1:0]   byte_q, byte_d;
  logic [TEMP_W-1:0]   shift_q, shift_d;
  logic [TEMP_W-1:0]   held_q, held_d;
  logic                miss_q, miss_d;
  logic [TICK_W-1:0]   dur;
  logic [TICK_W-1:0]   tick_inc;
  logic                wbit;
  logic                drive;
  logic                done;
  logic                abort_p;
  logic [2:0]          bit_old;

  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] d);
    return (d == '0) ? TICK_W'(1) : d;
  endfunction

  function automatic logic cmd_bit(input logic [1:0] byi, input logic [2:0] bi);
    logic [7:0] cmd;
    case (byi)
      2'd0:    cmd = 8'hCC;
      2'd1:    cmd = 8'h44;
      2'd2:    cmd = 8'hCC;
      default: cmd = 8'hBE;
    endcase
    return cmd[bi];
  endfunction

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    shift_d = shift_q;
    held_d  = held_q;
    miss_d  = miss_q;
    drive   = 1'b0;
    done    = 1'b0;
    abort_p = 1'b0;
    dur     = TICK_W'(1);
    bit_old = bit_q;

    if (phase_q == PH_IDLE && start_i) begin
      byte_d  = '0;
      bit_d   = '0;
      miss_d  = 1'b0;
      phase_d = PH_RST_LOW;
      tick_d  = '0;
    end

    wbit = cmd_bit(byte_d[1:0], bit_d);

    case (phase_d)
      PH_RST_LOW:   dur = at_least_one(cfg_i.reset_low_ticks);
      PH_RST_WAIT:  dur = at_least_one(cfg_i.presence_wait_ticks);
      PH_RST_RECOV: begin
        if (tick_d == '0) miss_d = level_i;
        dur = at_least_one(cfg_i.recovery_ticks);
      end
      PH_WR_LOW: begin
        dur = at_least_one(TICK_W'(wbit ? cfg_i.write_short_ticks
                                        : cfg_i.write_long_ticks));
      end
      PH_WR_HIGH: begin
        dur = at_least_one(TICK_W'(wbit ? cfg_i.write_long_ticks
                                        : cfg_i.write_short_ticks));
      end
      PH_RD_LOW:    dur = at_least_one(TICK_W'(cfg_i.read_low_ticks));
      PH_RD_REL:    dur = at_least_one(TICK_W'(cfg_i.read_release_ticks));
      PH_RD_TAIL: begin
        if (tick_d == '0 && level_i && byte_d < BYTE_W'(2)) begin
          shift_d[{byte_d[0], bit_d}] = 1'b1;
        end
        dur = at_least_one(TICK_W'(cfg_i.read_tail_ticks));
      end
      default: phase_d = PH_IDLE;
    endcase

    drive = (phase_d == PH_RST_LOW) || (phase_d == PH_WR_LOW) || (phase_d == PH_RD_LOW);
    tick_inc = tick_d + TICK_W'(1);
    bit_old  = bit_d;

    if (phase_d != PH_IDLE) begin
      tick_d = tick_inc;
      if (tick_inc >= dur) begin
        tick_d = '0;
        case (phase_d)
          PH_RST_LOW:  phase_d = PH_RST_WAIT;
          PH_RST_WAIT: phase_d = PH_RST_RECOV;
          PH_RST_RECOV: begin
            if (miss_d) begin
              abort_p = 1'b1;
              phase_d = PH_IDLE;
            end else begin
              bit_d   = '0;
              phase_d = PH_WR_LOW;
            end
          end
          PH_WR_LOW: phase_d = PH_WR_HIGH;
          PH_WR_HIGH: begin
            bit_d = bit_old + 3'd1;
            if (bit_old != 3'd7) begin
              phase_d = PH_WR_LOW;
            end else begin
              byte_d = byte_d + BYTE_W'(1);
              if (byte_d == BYTE_W'(2)) begin
                phase_d = PH_RST_LOW;
              end else if (byte_d >= BYTE_W'(4)) begin
                byte_d  = '0;
                shift_d = '0;
                phase_d = PH_RD_LOW;
              end else begin
                phase_d = PH_WR_LOW;
              end
            end
          end
          PH_RD_LOW: begin
            phase_d = (cfg_i.read_release_ticks == '0) ? PH_RD_TAIL : PH_RD_REL;
          end
          PH_RD_REL: phase_d = PH_RD_TAIL;
          PH_RD_TAIL: begin
            bit_d = bit_old + 3'd1;
            if (bit_old != 3'd7) begin
              phase_d = PH_RD_LOW;
            end else begin
              byte_d = byte_d + BYTE_W'(1);
              if (byte_d >= BYTE_W'(READ_BYTES)) begin
                held_d  = shift_d;
                done    = 1'b1;
                phase_d = PH_IDLE;
              end else begin
                phase_d = PH_RD_LOW;
              end
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end

    res_o.drive_low       = drive;
    res_o.busy_res        = (phase_d != PH_IDLE);
    res_o.done_res        = done;
    res_o.no_presence     = abort_p;
    res_o.temperature_raw = held_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      byte_q  <= '0;
      shift_q <= '0;
      held_q  <= '0;
      miss_q  <= 1'b0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
      held_q  <= held_d;
      miss_q  <= miss_d;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/owtr_checker.sv =====
// Checker: predicts every result of the 1-Wire read master and compares it with the block
`timescale 1ns / 1ps
module owtr_checker import owtr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  owtr_in_if                    tick_mon,
  owtr_out_if                   res_mon,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o,
  output int unsigned           done_count_o,
  output int unsigned           abort_count_o,
  output logic                  bus_idle_o,
  output logic                  presence_tick_o,
  output logic                  second_reset_o
);

  localparam logic [7:0] SKIP_ROM        = 8'hCC;
  localparam logic [7:0] CONVERT_T       = 8'h44;
  localparam logic [7:0] READ_SCRATCHPAD = 8'hBE;
  localparam int unsigned REPORT_LIMIT   = 10;

  cfg_t              timing;
  phase_e            phase;
  logic [TICK_W-1:0] tick_cnt;
  logic [2:0]        bit_idx;
  logic [2:0]        byte_idx;
  logic [TEMP_W-1:0] rx_word;
  logic [TEMP_W-1:0] temp_word;
  logic              presence_lost;
  res_t              tick_results_q[$];

  assign bus_idle_o      = (phase == PH_IDLE);
  assign presence_tick_o = (phase == PH_RST_RECOV) && (tick_cnt == '0);
  assign second_reset_o  = byte_idx[1];

  // zero duration counts as one tick
  function automatic logic [TICK_W-1:0] span(input logic [TICK_W-1:0] d);
    return (d == '0) ? TICK_W'(1) : d;
  endfunction

  function automatic void enter(input phase_e p);
    phase    = p;
    tick_cnt = '0;
  endfunction

  function automatic res_t advance_bus_tick(input logic start, input logic level);
    res_t              r;
    logic [TICK_W-1:0] dur;
    logic [7:0]        cmd;
    logic              wr_bit;
    logic [2:0]        b;
    r   = '0;
    dur = TICK_W'(1);
    if (phase == PH_IDLE && start) begin
      byte_idx      = '0;
      bit_idx       = '0;
      presence_lost = 1'b0;
      enter(PH_RST_LOW);
    end
    case (byte_idx[1:0])
      2'd1:    cmd = CONVERT_T;
      2'd3:    cmd = READ_SCRATCHPAD;
      default: cmd = SKIP_ROM;
    endcase
    wr_bit = cmd[bit_idx];
    case (phase)
      PH_RST_LOW:  dur = span(timing.reset_low_ticks);
      PH_RST_WAIT: dur = span(timing.presence_wait_ticks);
      PH_RST_RECOV: begin
        if (tick_cnt == '0) presence_lost = level;
        dur = span(timing.recovery_ticks);
      end
      PH_WR_LOW: dur = span(TICK_W'(wr_bit ? timing.write_short_ticks
                                           : timing.write_long_ticks));
      PH_WR_HIGH: dur = span(TICK_W'(wr_bit ? timing.write_long_ticks
                                            : timing.write_short_ticks));
      PH_RD_LOW: dur = span(TICK_W'(timing.read_low_ticks));
      PH_RD_REL: dur = span(TICK_W'(timing.read_release_ticks));
      PH_RD_TAIL: begin
        if (tick_cnt == '0 && level && byte_idx < 3'd2) rx_word[{byte_idx[0], bit_idx}] = 1'b1;
        dur = span(TICK_W'(timing.read_tail_ticks));
      end
      default: phase = PH_IDLE;
    endcase

    r.drive_low = (phase == PH_RST_LOW) || (phase == PH_WR_LOW) || (phase == PH_RD_LOW);

    if (phase != PH_IDLE) begin
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= dur) begin
        case (phase)
          PH_RST_LOW:  enter(PH_RST_WAIT);
          PH_RST_WAIT: enter(PH_RST_RECOV);
          PH_RST_RECOV: begin
            if (presence_lost) begin
              r.no_presence = 1'b1;
              enter(PH_IDLE);
            end else begin
              bit_idx = '0;
              enter(PH_WR_LOW);
            end
          end
          PH_WR_LOW: enter(PH_WR_HIGH);
          PH_WR_HIGH: begin
            b       = bit_idx;
            bit_idx = bit_idx + 1'b1;
            if (b != 3'd7) begin
              enter(PH_WR_LOW);
            end else begin
              byte_idx = byte_idx + 1'b1;
              if (byte_idx == 3'd2) begin
                enter(PH_RST_LOW);
              end else if (byte_idx >= 3'd4) begin
                byte_idx = '0;
                rx_word  = '0;
                enter(PH_RD_LOW);
              end else begin
                enter(PH_WR_LOW);
              end
            end
          end
          PH_RD_LOW: enter((timing.read_release_ticks == '0) ? PH_RD_TAIL : PH_RD_REL);
          PH_RD_REL: enter(PH_RD_TAIL);
          PH_RD_TAIL: begin
            b       = bit_idx;
            bit_idx = bit_idx + 1'b1;
            if (b != 3'd7) begin
              enter(PH_RD_LOW);
            end else begin
              byte_idx = byte_idx + 1'b1;
              if (byte_idx >= OWTR_READ_BYTES) begin
                temp_word   = rx_word;
                r.done_res  = 1'b1;
                enter(PH_IDLE);
              end else begin
                enter(PH_RD_LOW);
              end
            end
          end
          default: enter(PH_IDLE);
        endcase
      end
    end

    r.busy_res        = (phase != PH_IDLE);
    r.temperature_raw = temp_word;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t want;
    res_t got;
    if (!rst_ni) begin
      timing = '{RST_LOW_DEF, PRES_WAIT_DEF, RECOV_DEF, WR_SHORT_DEF, WR_LONG_DEF,
                 RD_LOW_DEF, RD_REL_DEF, RD_TAIL_DEF};
      phase         = PH_IDLE;
      tick_cnt      = '0;
      bit_idx       = '0;
      byte_idx      = '0;
      rx_word       = '0;
      temp_word     = '0;
      presence_lost = 1'b0;
      tick_results_q.delete();
      fail_count_o  = 0;
      pending_o     = 0;
      done_count_o  = 0;
      abort_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_RST_LOW:   timing.reset_low_ticks     = cfg_data_i;
          CFG_PRES_WAIT: timing.presence_wait_ticks = cfg_data_i;
          CFG_RECOV:     timing.recovery_ticks      = cfg_data_i;
          CFG_WR_SHORT:  timing.write_short_ticks   = cfg_data_i[SLOT_W-1:0];
          CFG_WR_LONG:   timing.write_long_ticks    = cfg_data_i[SLOT_W-1:0];
          CFG_RD_LOW:    timing.read_low_ticks      = cfg_data_i[SLOT_W-1:0];
          CFG_RD_REL:    timing.read_release_ticks  = cfg_data_i[SLOT_W-1:0];
          CFG_RD_TAIL:   timing.read_tail_ticks     = cfg_data_i[SLOT_W-1:0];
          default:       timing = timing;
        endcase
      end
      if (tick_mon.valid && tick_mon.ready) begin
        want = advance_bus_tick(tick_mon.start_req, tick_mon.line_level);
        if (want.done_res) done_count_o++;
        if (want.no_presence) abort_count_o++;
        tick_results_q.push_back(want);
      end
      if (res_mon.valid && res_mon.ready) begin
        got = '{drive_low: res_mon.drive_low, busy_res: res_mon.busy_res,
                done_res: res_mon.done_res, no_presence: res_mon.no_presence,
                temperature_raw: res_mon.temperature_raw};
        if (tick_results_q.size() == 0) begin
          if (fail_count_o < REPORT_LIMIT)
            $display({"%t: result with no request outstanding:",
                      " drive %b busy %b done %b nopres %b temp %h"},
                     $realtime, got.drive_low, got.busy_res, got.done_res, got.no_presence,
                     got.temperature_raw);
          fail_count_o++;
        end else begin
          want = tick_results_q.pop_front();
          if (got !== want) begin
            if (fail_count_o < REPORT_LIMIT)
              $display({"%t: mismatch (exp/act) drive %b/%b busy %b/%b done %b/%b",
                        " nopres %b/%b temp %h/%h"}, $realtime,
                       want.drive_low, got.drive_low, want.busy_res, got.busy_res,
                       want.done_res, got.done_res, want.no_presence, got.no_presence,
                       want.temperature_raw, got.temperature_raw);
            fail_count_o++;
          end
        end
      end
      pending_o = tick_results_q.size();
    end
  end

endmodule

// ===== tb/sv/one_wire_temperature_read_master_top_tb.sv =====
// Testbench top: drives tick requests and timing writes into the 1-Wire read master
`timescale 1ns / 1ps
module one_wire_temperature_read_master_top_tb;
  import owtr_pkg::*;

  typedef enum logic [1:0] {LVL_RANDOM, LVL_HIGH, LVL_LOW} line_mode_e;

  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned RANDOM_BURST = 40;
  localparam int unsigned RUN_LIMIT_NS = 4_000_000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned done_count;
  int unsigned abort_count;
  logic        bus_idle;
  logic        presence_tick;
  logic        second_reset;

  int unsigned send_idle_pct;
  int unsigned rcv_idle_pct;
  logic        hold_req;
  line_mode_e  line_mode;
  logic        fail_first;
  logic        fail_second;
  int unsigned items_sent;
  int unsigned settings_used;

  owtr_in_if  tick_if();
  owtr_out_if res_if();

  one_wire_temperature_read_master_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (tick_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  owtr_checker read_master_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tick_mon        (tick_if),
    .res_mon         (res_if),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .done_count_o    (done_count),
    .abort_count_o   (abort_count),
    .bus_idle_o      (bus_idle),
    .presence_tick_o (presence_tick),
    .second_reset_o  (second_reset)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Timed out with %0d results outstanding", pending);
    $display("FAIL one_wire_temperature_read_master_top");
    $finish;
  end

  // result side: random back-pressure plus one long hold on request
  initial begin : result_sink
    int unsigned hold_left;
    hold_left    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req     = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // entered and left just after a falling edge
  task automatic send_tick(input logic start);
    logic lvl;
    while ($urandom_range(99) < send_idle_pct) begin
      tick_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    if (presence_tick) begin
      lvl = second_reset ? fail_second : fail_first;
    end else begin
      case (line_mode)
        LVL_HIGH: lvl = 1'b1;
        LVL_LOW:  lvl = 1'b0;
        default:  lvl = 1'($urandom_range(1));
      endcase
    end
    tick_if.valid      <= 1'b1;
    tick_if.start_req  <= start;
    tick_if.line_level <= lvl;
    @(posedge clk_i);
    while (!tick_if.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic run_txn(input logic f1, input logic f2, input line_mode_e mode,
                         input int unsigned noise_pct);
    fail_first  = f1;
    fail_second = f2;
    line_mode   = mode;
    send_tick(1'b1);
    while (!bus_idle) send_tick($urandom_range(99) < noise_pct);
  endtask

  task automatic random_traffic(input int unsigned n);
    int unsigned sent;
    logic        start;
    sent = 0;
    while (sent < n || !bus_idle) begin
      if (bus_idle) begin
        start = ($urandom_range(99) < 35);
        if (start) begin
          fail_first  = ($urandom_range(99) < 8);
          fail_second = ($urandom_range(99) < 8);
          if ($urandom_range(9) == 0) line_mode = $urandom_range(1) ? LVL_HIGH : LVL_LOW;
          else line_mode = LVL_RANDOM;
        end
      end else begin
        start = ($urandom_range(99) < 5);
      end
      send_tick(start);
      sent++;
    end
  endtask

  task automatic settle();
    tick_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic program_timing(input cfg_t t);
    for (int i = 0; i < 8; i++) begin
      cfg_we  <= 1'b1;
      cfg_idx <= cfg_idx_e'(i);
      case (cfg_idx_e'(i))
        CFG_RST_LOW:   cfg_data <= t.reset_low_ticks;
        CFG_PRES_WAIT: cfg_data <= t.presence_wait_ticks;
        CFG_RECOV:     cfg_data <= t.recovery_ticks;
        CFG_WR_SHORT:  cfg_data <= CFG_DATA_W'(t.write_short_ticks);
        CFG_WR_LONG:   cfg_data <= CFG_DATA_W'(t.write_long_ticks);
        CFG_RD_LOW:    cfg_data <= CFG_DATA_W'(t.read_low_ticks);
        CFG_RD_REL:    cfg_data <= CFG_DATA_W'(t.read_release_ticks);
        CFG_RD_TAIL:   cfg_data <= CFG_DATA_W'(t.read_tail_ticks);
        default:       cfg_data <= '0;
      endcase
      @(negedge clk_i);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic cfg_t short_timing();
    cfg_t t;
    t.reset_low_ticks     = TICK_W'($urandom_range(3));
    t.presence_wait_ticks = TICK_W'($urandom_range(3));
    t.recovery_ticks      = TICK_W'($urandom_range(3));
    t.write_short_ticks   = SLOT_W'($urandom_range(2));
    t.write_long_ticks    = SLOT_W'($urandom_range(3));
    t.read_low_ticks      = SLOT_W'($urandom_range(2));
    t.read_release_ticks  = SLOT_W'($urandom_range(2));
    t.read_tail_ticks     = SLOT_W'($urandom_range(2));
    return t;
  endfunction

  initial begin
    tick_if.valid      = 1'b0;
    tick_if.start_req  = 1'b0;
    tick_if.line_level = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_RST_LOW;
    cfg_data           = '0;
    hold_req           = 1'b0;
    send_idle_pct      = 23;
    rcv_idle_pct       = 75;
    line_mode          = LVL_RANDOM;
    fail_first         = 1'b0;
    fail_second        = 1'b0;
    items_sent         = 0;
    settings_used      = 0;
    rst_ni             = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // shortest slots, released phase of the read slot skipped
    program_timing('{10'd1, 10'd1, 10'd1, 8'd1, 8'd1, 8'd1, 8'd0, 8'd1});
    run_txn(1'b0, 1'b0, LVL_HIGH, 0);
    run_txn(1'b1, 1'b0, LVL_RANDOM, 0);
    run_txn(1'b0, 1'b1, LVL_RANDOM, 0);
    repeat (4) send_tick(1'b0);
    settle();

    // all durations zero, starts offered while busy
    program_timing('0);
    run_txn(1'b0, 1'b0, LVL_RANDOM, 60);
    settle();

    send_idle_pct = 75;
    rcv_idle_pct  = 23;
    program_timing(short_timing());
    random_traffic(RANDOM_BURST);
    settle();

    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    program_timing(short_timing());
    hold_req = 1'b1;
    random_traffic(RANDOM_BURST);
    settle();

    $display("Sent %0d tick requests across %0d timing settings and three idle mixes",
             items_sent, settings_used);
    $display("Reads completed %0d, presence aborts %0d, mismatches %0d",
             done_count, abort_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS one_wire_temperature_read_master_top");
    end else begin
      $display("FAIL one_wire_temperature_read_master_top");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/owtr_pkg.sv
sv/owtr_in_if.sv
sv/owtr_out_if.sv
sv/owtr_core.sv
sv/one_wire_temperature_read_master_top.sv
tb/sv/owtr_checker.sv
tb/sv/one_wire_temperature_read_master_top_tb.sv
